// ===== src/patb_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and control types of the per-address traffic blocker
// no dependencies

package patb_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam logic [63:0] THRESHOLD_RESET = 64'd1048576;
   localparam logic [7:0]  LIMIT_RESET     = 8'd3;
   localparam logic [31:0] OWN_RESET       = 32'd0;
   localparam logic [7:0]  WARN_MAX        = 8'hFF;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 152;
   localparam int RSP_USER_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN       = 2'd2;

   localparam logic [2:0] VERDICT_OWN     = 3'd0;
   localparam logic [2:0] VERDICT_ADDED   = 3'd1;
   localparam logic [2:0] VERDICT_UPDATED = 3'd2;
   localparam logic [2:0] VERDICT_WARNING = 3'd3;
   localparam logic [2:0] VERDICT_NEWLY   = 3'd4;
   localparam logic [2:0] VERDICT_BLOCKED = 3'd5;
   localparam logic [2:0] VERDICT_FULL    = 3'd6;

   typedef struct packed {
      logic [63:0] sent;
      logic [63:0] received;
      logic [7:0]  warnings;
      logic        blocked;
   } patb_entry_type;

   typedef struct packed {
      logic load_item;
      logic search;
      logic add;
      logic write_update;
      logic write_insert;
      logic emit_own;
      logic emit_full;
   } patb_cmd_type;

   typedef struct packed {
      logic own;
      logic hit;
      logic miss;
      logic full;
      logic out_free;
   } patb_sts_type;

endpackage

// ===== src/per_address_traffic_blocker.sv =====
`timescale 1ns / 1ps
// an own-address item goes from accept through the search state straight to its result; other items
// first scan the key ram, one stored address per cycle, then update, insert or report a full table
// one item at a time: a new item is accepted only once the result of the last one is registered
// reset: synchronous active high; config back to defaults, entry count to zero,
// table contents left unknown (no clearing pass); depends on patb_pkg, patb_ctrl, patb_dp

module per_address_traffic_blocker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // peer_address, bytes_out, bytes_in
   input  logic [patb_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // slot_index, warnings_now, blocked_now, sent_total, received_total, zero pad
   output logic [patb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // verdict
   output logic [patb_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [patb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [patb_pkg::CSR_DATA_W-1:0] csr_data
);

   import patb_pkg::*;

   patb_cmd_type cmd;
   patb_sts_type sts;

   patb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   patb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ===== src/patb_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module patb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/patb_ctrl.sv =====
`timescale 1ns / 1ps
// controller fsm: accept, table search, update, insert, own or full result
// depends on patb_pkg

module patb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  patb_pkg::patb_sts_type sts,
   output patb_pkg::patb_cmd_type cmd
);

   import patb_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_HIT    = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_INSERT = 3'd4;
   localparam logic [2:0] S_OWN    = 3'd5;
   localparam logic [2:0] S_FULL   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_SEARCH;
            end
         end
         S_SEARCH: begin
            priority if (sts.own) begin
               state_in = S_OWN;
            end else if (sts.hit) begin
               state_in = S_HIT;
            end else if (sts.miss) begin
               state_in = sts.full ? S_FULL : S_INSERT;
            end else begin
               cmd.search = 1'b1;
            end
         end
         S_HIT: begin
            cmd.add  = 1'b1;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (sts.out_free) begin
               cmd.write_update = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_INSERT: begin
            if (sts.out_free) begin
               cmd.write_insert = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_OWN: begin
            if (sts.out_free) begin
               cmd.emit_own = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FULL: begin
            if (sts.out_free) begin
               cmd.emit_full = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/patb_dp.sv =====
`timescale 1ns / 1ps
// datapath: configuration registers, table memories, search counters,
// saturating totals, warning logic and output register; depends on patb_pkg, patb_ram

module patb_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [patb_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [patb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [patb_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [patb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [patb_pkg::CSR_DATA_W-1:0] csr_data,
   input  patb_pkg::patb_cmd_type  cmd,
   output patb_pkg::patb_sts_type  sts
);

   import patb_pkg::*;

   // configuration
   logic [63:0] thr_ff;
   logic [7:0]  limit_ff;
   logic [31:0] own_ff;

   // current item
   logic [31:0] addr_ff;
   logic [31:0] bout_ff;
   logic [31:0] bin_ff;

   // search
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0] used_ff;

   // entry under update
   patb_entry_type   hold_ff;
   logic [IDX_W-1:0] slot_ff;
   logic [63:0]      sent_ff;
   logic [63:0]      recv_ff;
   logic [7:0]       warn_ff;
   logic             blk_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [2:0]            verdict_ff, verdict_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [31:0]      key_rd;
   patb_entry_type   entry_rd;
   patb_entry_type   entry_wr;
   patb_entry_type   entry_upd;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] used_idx;
   logic [2:0]       verdict_upd;
   logic [7:0]       warn_inc;
   logic             over;
   logic             emit;
   logic [64:0]      sum_sent;
   logic [64:0]      sum_recv;

   assign csr_ready = 1'b1;
   assign used_idx  = used_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RESET;
         limit_ff <= LIMIT_RESET;
         own_ff   <= OWN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: thr_ff   <= csr_data;
            CSR_LIMIT:     limit_ff <= csr_data[7:0];
            CSR_OWN:       own_ff   <= csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         addr_ff <= req_tdata[31:0];
         bout_ff <= req_tdata[63:32];
         bin_ff  <= req_tdata[95:64];
      end
   end

   // scan issues one address a cycle, compare happens in the next cycle
   always_comb begin
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      if (cmd.load_item) begin
         scan_in = '0;
      end else if (cmd.search) begin
         pend_in     = scan_ff < used_ff;
         pend_idx_in = scan_ff[IDX_W-1:0];
         if (scan_ff < used_ff) begin
            scan_in = scan_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         pend_ff <= 1'b0;
         used_ff <= '0;
      end else begin
         scan_ff <= scan_in;
         pend_ff <= pend_in;
         if (cmd.write_insert) begin
            used_ff <= used_ff + CNT_W'(1);
         end
      end
      pend_idx_ff <= pend_idx_in;
   end

   assign sts.own      = addr_ff == own_ff;
   assign sts.hit      = pend_ff && (key_rd == addr_ff);
   assign sts.miss     = !pend_ff && (scan_ff >= used_ff);
   assign sts.full     = used_ff == CNT_W'(TABLE_ENTRIES);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // saturating totals
   assign sum_sent = {1'b0, hold_ff.sent} + {33'd0, bout_ff};
   assign sum_recv = {1'b0, hold_ff.received} + {33'd0, bin_ff};

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         hold_ff <= entry_rd;
         slot_ff <= pend_idx_ff;
      end
      if (cmd.add) begin
         sent_ff <= sum_sent[64] ? '1 : sum_sent[63:0];
         recv_ff <= sum_recv[64] ? '1 : sum_recv[63:0];
         warn_ff <= hold_ff.warnings;
         blk_ff  <= hold_ff.blocked;
      end
   end

   always_comb begin
      over      = (sent_ff > thr_ff) || (recv_ff > thr_ff);
      warn_inc  = (warn_ff != WARN_MAX) ? warn_ff + 8'd1 : warn_ff;
      entry_upd = '{sent: sent_ff, received: recv_ff, warnings: warn_ff, blocked: blk_ff};
      priority if (blk_ff) begin
         verdict_upd = VERDICT_BLOCKED;
      end else if (over) begin
         entry_upd.warnings = warn_inc;
         if (warn_inc >= limit_ff) begin
            entry_upd.blocked = 1'b1;
            verdict_upd       = VERDICT_NEWLY;
         end else begin
            verdict_upd = VERDICT_WARNING;
         end
      end else begin
         verdict_upd = VERDICT_UPDATED;
      end
   end

   always_comb begin
      if (cmd.write_insert) begin
         wr_addr  = used_idx;
         entry_wr = '{sent: {32'd0, bout_ff}, received: {32'd0, bin_ff},
                      warnings: 8'd0, blocked: 1'b0};
      end else begin
         wr_addr  = slot_ff;
         entry_wr = entry_upd;
      end
   end

   patb_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.write_insert),
      .wr_addr (used_idx),
      .wr_data (addr_ff),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (key_rd)
   );

   patb_ram #(
      .WIDTH ($bits(patb_entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.write_insert || cmd.write_update),
      .wr_addr (wr_addr),
      .wr_data (entry_wr),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (entry_rd)
   );

   // result packing: slot, warnings, blocked, sent, received
   always_comb begin
      emit        = cmd.write_update || cmd.write_insert || cmd.emit_own || cmd.emit_full;
      verdict_in  = VERDICT_OWN;
      rsp_data_in = '0;
      priority if (cmd.write_update) begin
         verdict_in  = verdict_upd;
         rsp_data_in = {7'd0, entry_upd.received, entry_upd.sent, entry_upd.blocked,
                        entry_upd.warnings, 8'(slot_ff)};
      end else if (cmd.write_insert) begin
         verdict_in  = VERDICT_ADDED;
         rsp_data_in = {7'd0, 32'd0, bin_ff, 32'd0, bout_ff, 1'b0, 8'd0, 8'(used_idx)};
      end else if (cmd.emit_full) begin
         verdict_in = VERDICT_FULL;
      end else begin
         verdict_in = VERDICT_OWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         verdict_ff  <= verdict_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = verdict_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count beyond table size");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.write_insert |-> !sts.full)
      else $error("insert into a full table");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   a_pend_in_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ({1'b0, pend_idx_ff} < (IDX_W + 1)'(used_ff)))
      else $error("compare of an entry never written");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_update, cmd.write_insert, cmd.emit_own, cmd.emit_full}))
      else $error("more than one result in a cycle");

endmodule
